FILE: rtl/salm_pkg.sv
`default_nettype none
package salm_pkg;

  typedef enum logic [1:0] {
    CMD_ACCEL = 2'd0,
    CMD_HUM   = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_POWER = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef enum logic [1:0] {
    REG_HUM_LOW  = 2'd0,
    REG_HUM_HIGH = 2'd1
  } reg_idx_t;

  localparam int unsigned CfgIdxW = 2;
  localparam logic [9:0] HumLowReset  = 10'd300;
  localparam logic [9:0] HumHighReset = 10'd700;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SUM,
    ST_DIV,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic write;
    logic sum_clear;
    logic sum_step;
    logic div_start;
    logic finish;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sample;
    logic sum_done;
    logic div_done;
  } dp_stat_t;

endpackage
`default_nettype wire

FILE: rtl/sensor_average_led_monitor_top.sv
`default_nettype none
// Averages accelerometer and humidity samples over a ring of the last
// WINDOW_DEPTH samples and drives four LED levels, one result beat per input
// beat. Items are taken one at a time. Ticks, power commands and samples
// while off raise the result straight from the write state; a sample while
// on raises it after the serial sweep of the filled window entries and the
// bit-serial divider by the fill count. A stalled result holds the input.
// The user must write limits on the cfg port only while idle; the block
// itself does not enforce it.
module sensor_average_led_monitor_top #(
  parameter int unsigned WINDOW_DEPTH = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_cmd,
  input  wire logic signed [15:0] in_accel_x,
  input  wire logic signed [15:0] in_accel_y,
  input  wire logic signed [15:0] in_accel_z,
  input  wire logic [9:0]         in_humidity_sample,
  input  wire logic               in_power_on,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_blue_led,
  output logic                    out_red_led,
  output logic                    out_green_led,
  output logic                    out_yellow_led,
  output logic signed [15:0]      out_mean_x,
  output logic signed [15:0]      out_mean_y,
  output logic signed [15:0]      out_mean_z,
  output logic [9:0]              out_mean_humidity,
  output logic [1:0]              out_dominant_axis,
  output logic                    out_axis_changed,
  output logic                    out_humidity_danger,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [salm_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [9:0]         cfg_data
);
  salm_pkg::dp_cmd_t  dcmd;
  salm_pkg::dp_stat_t dstat;
  logic idle, in_fire;
  logic [9:0] low_r, high_r;
  logic [3:0] leds;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= salm_pkg::HumLowReset;
      high_r <= salm_pkg::HumHighReset;
    end else if (cfg_valid) begin
      if (cfg_index == salm_pkg::REG_HUM_LOW)  low_r  <= cfg_data;
      if (cfg_index == salm_pkg::REG_HUM_HIGH) high_r <= cfg_data;
    end
  end

  assign in_ready = idle;
  assign in_fire  = in_valid && in_ready;

  salm_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .out_busy(out_valid && !out_ready),
    .stat(dstat), .cmd(dcmd), .idle
  );

  salm_dp #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_dp (
    .clk, .rst_n, .cmd(dcmd), .stat(dstat),
    .in_cmd, .in_accel_x, .in_accel_y, .in_accel_z, .in_humidity_sample,
    .in_power_on, .hum_low(low_r), .hum_high(high_r),
    .res_valid(out_valid), .res_leds(leds),
    .res_mx(out_mean_x), .res_my(out_mean_y), .res_mz(out_mean_z),
    .res_mh(out_mean_humidity), .res_axis(out_dominant_axis),
    .res_changed(out_axis_changed), .res_danger(out_humidity_danger)
  );

  assign {out_blue_led, out_red_led, out_green_led, out_yellow_led} = leds;

  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_axis_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_dominant_axis != 2'd3) else $error("bad axis");
  a_off_dark: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_blue_led && out_humidity_danger) |-> 1'b0)
    else $error("danger while off");
endmodule
`default_nettype wire

FILE: rtl/salm_ram.sv
`default_nettype none
module salm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                                           clk,
  input  wire logic                                           we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                               wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                               rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: rtl/salm_ctrl.sv
`default_nettype none
module salm_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_fire,
  input  wire logic               out_busy,
  input  wire salm_pkg::dp_stat_t stat,
  output salm_pkg::dp_cmd_t       cmd,
  output logic                    idle
);
  salm_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= salm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      salm_pkg::ST_IDLE: begin
        if (in_fire) state_nxt = salm_pkg::ST_WRITE;
      end
      salm_pkg::ST_WRITE: begin
        state_nxt = stat.sample ? salm_pkg::ST_SUM : salm_pkg::ST_OUT;
      end
      salm_pkg::ST_SUM: begin
        if (stat.sum_done) state_nxt = salm_pkg::ST_DIV;
      end
      salm_pkg::ST_DIV: begin
        if (stat.div_done) state_nxt = salm_pkg::ST_OUT;
      end
      salm_pkg::ST_OUT: begin
        if (!out_busy) state_nxt = salm_pkg::ST_IDLE;
      end
      default: state_nxt = salm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    idle = 1'b0;
    unique case (state_r)
      salm_pkg::ST_IDLE: begin
        idle     = 1'b1;
        cmd.load = in_fire;
      end
      salm_pkg::ST_WRITE: begin
        cmd.write     = 1'b1;
        cmd.sum_clear = 1'b1;
      end
      salm_pkg::ST_SUM: begin
        cmd.sum_step  = 1'b1;
        cmd.div_start = stat.sum_done;
      end
      salm_pkg::ST_DIV: ;
      salm_pkg::ST_OUT: begin
        cmd.finish = !out_busy;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

FILE: rtl/salm_dp.sv
`default_nettype none
module salm_dp #(
  parameter int unsigned WINDOW_DEPTH = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire salm_pkg::dp_cmd_t   cmd,
  output salm_pkg::dp_stat_t       stat,
  input  wire logic [1:0]          in_cmd,
  input  wire logic signed [15:0]  in_accel_x,
  input  wire logic signed [15:0]  in_accel_y,
  input  wire logic signed [15:0]  in_accel_z,
  input  wire logic [9:0]          in_humidity_sample,
  input  wire logic                in_power_on,
  input  wire logic [9:0]          hum_low,
  input  wire logic [9:0]          hum_high,
  output logic                     res_valid,
  output logic [3:0]               res_leds,
  output logic signed [15:0]       res_mx,
  output logic signed [15:0]       res_my,
  output logic signed [15:0]       res_mz,
  output logic [9:0]               res_mh,
  output logic [1:0]               res_axis,
  output logic                     res_changed,
  output logic                     res_danger
);
  localparam int unsigned AW  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned FW  = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SW  = 16 + FW;
  localparam int unsigned DCW = $clog2(SW + 1);
  localparam logic [FW-1:0] FillMax = FW'(WINDOW_DEPTH);

  logic [1:0]        cmd_r;
  logic signed [15:0] ax_r, ay_r, az_r;
  logic [9:0]        hs_r;
  logic              pon_r;
  logic              powered_r;
  logic              blue_r, red_r, green_r, yellow_r;
  logic [AW-1:0]     aslot_r, hslot_r;
  logic [FW-1:0]     afill_r, hfill_r;
  logic signed [15:0] mx_r, my_r, mz_r;
  logic [9:0]        mh_r;
  logic [1:0]        prev_r;
  logic              changed_r, danger_r, valid_r;

  logic is_acc, is_hum;
  assign is_acc = (cmd_r == salm_pkg::CMD_ACCEL);
  assign is_hum = (cmd_r == salm_pkg::CMD_HUM);
  assign stat.sample = powered_r && (is_acc || is_hum);

  logic [FW-1:0] fill;
  assign fill = is_acc ? afill_r : hfill_r;

  // read address sweep
  logic [FW-1:0] ridx_r;
  logic          rv_r;
  logic [AW-1:0] raddr;
  assign raddr = ridx_r[AW-1:0];

  logic [47:0] a_rd;
  logic [9:0]  h_rd;

  salm_ram #(.WIDTH(48), .DEPTH(WINDOW_DEPTH)) u_aram (
    .clk, .we(cmd.write && powered_r && is_acc), .waddr(aslot_r),
    .wdata({az_r, ay_r, ax_r}), .raddr(raddr), .rdata(a_rd)
  );
  salm_ram #(.WIDTH(10), .DEPTH(WINDOW_DEPTH)) u_hram (
    .clk, .we(cmd.write && powered_r && is_hum), .waddr(hslot_r),
    .wdata(hs_r), .raddr(raddr), .rdata(h_rd)
  );

  logic signed [SW-1:0] sx_r, sy_r, sz_r;
  logic [SW-1:0]        sh_r;
  logic                 issued;
  assign issued = (ridx_r == fill);
  assign stat.sum_done = cmd.sum_step && issued && !rv_r;

  // serial restoring divider, three lanes of magnitude plus humidity
  logic [SW-1:0] q_r [4];
  logic [FW:0]   rm_r [4];
  logic [3:0]    neg_r;
  logic [DCW-1:0] dcnt_r;
  logic          dbusy_r;
  assign stat.div_done = dbusy_r && (dcnt_r == '0);

  logic [FW:0] rsh [4];
  logic [SW-1:0] qn [4];
  logic [FW:0] rn [4];
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rsh[k] = {rm_r[k][FW-1:0], q_r[k][SW-1]};
      qn[k]  = {q_r[k][SW-2:0], 1'b0};
      rn[k]  = rsh[k];
      if (rsh[k] >= {1'b0, fill}) begin
        rn[k]    = rsh[k] - {1'b0, fill};
        qn[k][0] = 1'b1;
      end
    end
  end

  logic [SW-1:0] qs [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qs[k] = neg_r[k] ? (~q_r[k] + 1'b1) : q_r[k];
    end
  end

  // tick decision
  logic [15:0] absx, absy, absz, best;
  logic [1:0]  axis;
  logic        dng;
  always_comb begin
    absx = mx_r[15] ? 16'(-mx_r) : 16'(mx_r);
    absy = my_r[15] ? 16'(-my_r) : 16'(my_r);
    absz = mz_r[15] ? 16'(-mz_r) : 16'(mz_r);
    axis = salm_pkg::AXIS_X;
    best = absx;
    if (absy > best) begin
      axis = salm_pkg::AXIS_Y;
      best = absy;
    end
    if (absz > best) axis = salm_pkg::AXIS_Z;
    dng = (mh_r <= hum_low) || (mh_r >= hum_high);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_cmd;
      ax_r  <= in_accel_x;
      ay_r  <= in_accel_y;
      az_r  <= in_accel_z;
      hs_r  <= in_humidity_sample;
      pon_r <= in_power_on;
    end
    if (cmd.sum_clear) begin
      sx_r <= '0;
      sy_r <= '0;
      sz_r <= '0;
      sh_r <= '0;
    end else if (cmd.sum_step && rv_r) begin
      sx_r <= sx_r + SW'(signed'(a_rd[15:0]));
      sy_r <= sy_r + SW'(signed'(a_rd[31:16]));
      sz_r <= sz_r + SW'(signed'(a_rd[47:32]));
      sh_r <= sh_r + SW'(h_rd);
    end
    if (cmd.div_start) begin
      q_r[0] <= sx_r[SW-1] ? SW'(-sx_r) : SW'(sx_r);
      q_r[1] <= sy_r[SW-1] ? SW'(-sy_r) : SW'(sy_r);
      q_r[2] <= sz_r[SW-1] ? SW'(-sz_r) : SW'(sz_r);
      q_r[3] <= sh_r;
      neg_r  <= {1'b0, sz_r[SW-1], sy_r[SW-1], sx_r[SW-1]};
      for (int k = 0; k < 4; k++) rm_r[k] <= '0;
    end else if (dbusy_r && dcnt_r != '0) begin
      for (int k = 0; k < 4; k++) begin
        q_r[k]  <= qn[k];
        rm_r[k] <= rn[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      powered_r <= 1'b0;
      {blue_r, red_r, green_r, yellow_r} <= '0;
      aslot_r   <= '0;
      hslot_r   <= '0;
      afill_r   <= '0;
      hfill_r   <= '0;
      mx_r      <= '0;
      my_r      <= '0;
      mz_r      <= '0;
      mh_r      <= '0;
      prev_r    <= salm_pkg::AXIS_X;
      changed_r <= 1'b0;
      danger_r  <= 1'b0;
      valid_r   <= 1'b0;
      ridx_r    <= '0;
      rv_r      <= 1'b0;
      dbusy_r   <= 1'b0;
      dcnt_r    <= '0;
    end else begin
      rv_r <= 1'b0;
      if (cmd.finish) valid_r <= 1'b0;
      if (cmd.sum_clear) ridx_r <= '0;
      if (cmd.sum_step && !issued) begin
        ridx_r <= ridx_r + 1'b1;
        rv_r   <= 1'b1;
      end
      if (cmd.div_start) begin
        dbusy_r <= 1'b1;
        dcnt_r  <= DCW'(SW);
      end else if (dbusy_r) begin
        if (dcnt_r == '0) begin
          dbusy_r <= 1'b0;
          if (is_acc) begin
            mx_r <= 16'(qs[0]);
            my_r <= 16'(qs[1]);
            mz_r <= 16'(qs[2]);
          end else begin
            mh_r <= 10'(q_r[3]);
          end
          valid_r <= 1'b1;
        end else begin
          dcnt_r <= dcnt_r - 1'b1;
        end
      end
      if (cmd.write) begin
        changed_r <= 1'b0;
        danger_r  <= 1'b0;
        unique case (cmd_r)
          salm_pkg::CMD_ACCEL: begin
            if (powered_r) begin
              red_r   <= !red_r;
              aslot_r <= (aslot_r == AW'(WINDOW_DEPTH - 1)) ? '0 : aslot_r + 1'b1;
              if (afill_r != FillMax) afill_r <= afill_r + 1'b1;
            end else begin
              valid_r <= 1'b1;
            end
          end
          salm_pkg::CMD_HUM: begin
            if (powered_r) begin
              hslot_r <= (hslot_r == AW'(WINDOW_DEPTH - 1)) ? '0 : hslot_r + 1'b1;
              if (hfill_r != FillMax) hfill_r <= hfill_r + 1'b1;
            end else begin
              valid_r <= 1'b1;
            end
          end
          salm_pkg::CMD_TICK: begin
            blue_r    <= powered_r;
            prev_r    <= axis;
            changed_r <= (axis != prev_r);
            if (powered_r) begin
              green_r  <= (axis == salm_pkg::AXIS_Z);
              yellow_r <= dng;
              danger_r <= dng;
            end
            valid_r <= 1'b1;
          end
          salm_pkg::CMD_POWER: begin
            powered_r <= pon_r;
            if (pon_r) begin
              blue_r <= 1'b1;
            end else begin
              {blue_r, red_r, green_r, yellow_r} <= '0;
            end
            valid_r <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  assign res_valid   = valid_r;
  assign res_leds    = {blue_r, red_r, green_r, yellow_r};
  assign res_mx      = mx_r;
  assign res_my      = my_r;
  assign res_mz      = mz_r;
  assign res_mh      = mh_r;
  assign res_axis    = prev_r;
  assign res_changed = changed_r;
  assign res_danger  = danger_r;
endmodule
`default_nettype wire
